FILE: rtl/core/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// shared widths, limits and types for the segment pair intersection pipeline
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int CW     = 32;            // coordinate width
  localparam int DW     = CW + 1;        // coordinate difference
  localparam int PW     = 2 * DW;        // signed product of two differences
  localparam int MW     = PW - 1;        // magnitude of a cross or a squared length
  localparam int LO_W   = 33;            // low split of a wide multiplicand
  localparam int HI_W   = MW - LO_W;     // high split of a wide multiplicand
  localparam int TW     = 16;            // tolerance width
  localparam int IN_W   = 8 * CW;
  localparam int OUT_W  = 72;
  localparam int USER_W = 1;

  localparam int QB      = 36;           // quotient bits of the rounding divider
  localparam int DIV_NW  = 99;           // dividend 2*|n| + |d|
  localparam int DIV_DW  = MW + 1;       // divisor 2*|d|
  localparam int DIV_RW  = DIV_DW + QB;  // partial remainder
  localparam int DIV_LAT = QB + 2;

  localparam logic [TW-1:0]        TOL_RESET = TW'(1);
  localparam logic [QB-1:0]        Q_LIMIT   = QB'(64'h4_0000_0000);
  localparam logic signed [CW-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic hit;
    logic pv;
  } spi_flags_t;

endpackage

FILE: rtl/core/segment_pair_intersection.sv
// ----------------------------------------------------------------------------
// segment_pair_intersection
// tolerant intersection test of two 2-D fixed point segments with the line
// crossing point, one segment pair per cycle
// ----------------------------------------------------------------------------
// Takes one segment pair per clock; the pipeline never stops on its own,
// only when the output side holds off. The latency is set by the 38-stage
// rounding divider that places the crossing point; the hit and degenerate
// tests finish early and wait beside it. The tolerance register is to be
// written by the user only while no transfer is in flight (not enforced).
module segment_pair_intersection #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [spi_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hit, cross_x, cross_y, zero fill
  output logic [spi_pkg::OUT_W-1:0]    m_axis_tdata,
  // point_valid
  output logic [spi_pkg::USER_W-1:0]   m_axis_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spi_pkg::TW-1:0]       cfg_data
);
  import spi_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int NST  = 6 + DIV_LAT;
  localparam int FD   = NST - 8;
  localparam int SLW  = DW + 2 + F;
  localparam int SRW  = TW + DW;
  localparam int SCW  = (SLW > SRW) ? SLW + 1 : SRW + 1;
  localparam int MLW  = PW + 1 + F;
  localparam int MRW  = TW + MW;
  localparam int MCW  = (MLW > MRW) ? MLW + 1 : MRW + 1;
  localparam int X2W  = 2 * MW;
  localparam int RW2  = X2W + 2 * TW;
  localparam int PCW  = (X2W + 2 * F > RW2) ? X2W + 2 * F : RW2;
  localparam int ANW  = DIV_NW - 2;

  typedef struct packed {
    logic ab_short;
    logic cd_short;
    logic w_short;
    logic a_ok;
    logic c_ok;
  } deg_t;

  logic            adv;
  logic [NST:1]    vld;
  logic [TW-1:0]   tol;

  assign adv           = !vld[NST] || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      tol <= TOL_RESET;
    end else begin
      if (adv) begin
        vld <= {vld[NST-1:1], s_axis_tvalid};
      end
      if (cfg_valid) begin
        tol <= cfg_data;
      end
    end
  end

  // stage 1: differences
  logic signed [CW-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy, in_dx, in_dy;
  assign in_ax = s_axis_tdata[0*CW +: CW];
  assign in_ay = s_axis_tdata[1*CW +: CW];
  assign in_bx = s_axis_tdata[2*CW +: CW];
  assign in_by = s_axis_tdata[3*CW +: CW];
  assign in_cx = s_axis_tdata[4*CW +: CW];
  assign in_cy = s_axis_tdata[5*CW +: CW];
  assign in_dx = s_axis_tdata[6*CW +: CW];
  assign in_dy = s_axis_tdata[7*CW +: CW];

  logic signed [CW-1:0] s1_ax, s1_ay;
  logic signed [DW-1:0] s1_abx, s1_aby, s1_cdx, s1_cdy, s1_acx, s1_acy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax  <= in_ax;
      s1_ay  <= in_ay;
      s1_abx <= DW'(in_bx) - DW'(in_ax);
      s1_aby <= DW'(in_by) - DW'(in_ay);
      s1_cdx <= DW'(in_dx) - DW'(in_cx);
      s1_cdy <= DW'(in_dy) - DW'(in_cy);
      s1_acx <= DW'(in_cx) - DW'(in_ax);
      s1_acy <= DW'(in_cy) - DW'(in_ay);
    end
  end

  // stage 2: products, axis choice for the point-in-segment tests
  logic signed [DW-1:0] abs_abx, abs_aby, abs_cdx, abs_cdy;
  logic signed [DW:0]   sa_n, sa_d, sc_n, sc_d;

  always_comb begin
    abs_abx = s1_abx[DW-1] ? -s1_abx : s1_abx;
    abs_aby = s1_aby[DW-1] ? -s1_aby : s1_aby;
    abs_cdx = s1_cdx[DW-1] ? -s1_cdx : s1_cdx;
    abs_cdy = s1_cdy[DW-1] ? -s1_cdy : s1_cdy;
    if (abs_cdx >= abs_cdy) begin
      sa_n = -(DW+1)'(s1_acx);
      sa_d = (DW+1)'(s1_cdx);
    end else begin
      sa_n = -(DW+1)'(s1_acy);
      sa_d = (DW+1)'(s1_cdy);
    end
    if (sa_d[DW]) begin
      sa_n = -sa_n;
      sa_d = -sa_d;
    end
    if (abs_abx >= abs_aby) begin
      sc_n = (DW+1)'(s1_acx);
      sc_d = (DW+1)'(s1_abx);
    end else begin
      sc_n = (DW+1)'(s1_acy);
      sc_d = (DW+1)'(s1_aby);
    end
    if (sc_d[DW]) begin
      sc_n = -sc_n;
      sc_d = -sc_d;
    end
  end

  logic signed [PW-1:0] s2_abx2, s2_aby2, s2_cdx2, s2_cdy2, s2_acx2, s2_acy2;
  logic signed [PW-1:0] s2_d1, s2_d2, s2_n1a, s2_n1b, s2_n2a, s2_n2b;
  logic [2*TW-1:0]      s2_t2;
  logic signed [DW:0]   s2_sa_num, s2_sc_num;
  logic [DW-1:0]        s2_sa_den, s2_sc_den;
  logic signed [CW-1:0] s2_ax, s2_ay;
  logic signed [DW-1:0] s2_abx, s2_aby;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_abx2   <= s1_abx * s1_abx;
      s2_aby2   <= s1_aby * s1_aby;
      s2_cdx2   <= s1_cdx * s1_cdx;
      s2_cdy2   <= s1_cdy * s1_cdy;
      s2_acx2   <= s1_acx * s1_acx;
      s2_acy2   <= s1_acy * s1_acy;
      s2_d1     <= s1_aby * s1_cdx;
      s2_d2     <= s1_abx * s1_cdy;
      s2_n1a    <= s1_acy * s1_cdx;
      s2_n1b    <= s1_acx * s1_cdy;
      s2_n2a    <= s1_acy * s1_abx;
      s2_n2b    <= s1_acx * s1_aby;
      s2_t2     <= tol * tol;
      s2_sa_num <= sa_n;
      s2_sa_den <= DW'(sa_d);
      s2_sc_num <= sc_n;
      s2_sc_den <= DW'(sc_d);
      s2_ax     <= s1_ax;
      s2_ay     <= s1_ay;
      s2_abx    <= s1_abx;
      s2_aby    <= s1_aby;
    end
  end

  // stage 3: sums and the small range test operands
  logic [MW-1:0]        s3_ab2, s3_cd2, s3_w2;
  logic signed [PW-1:0] s3_den, s3_n1, s3_n2;
  logic signed [SLW-1:0] s3_sa_lhs, s3_sc_lhs;
  logic [SRW-1:0]       s3_sa_rhs, s3_sc_rhs;
  logic [2*TW-1:0]      s3_t2;
  logic signed [CW-1:0] s3_ax, s3_ay;
  logic signed [DW-1:0] s3_abx, s3_aby;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ab2 <= MW'(s2_abx2) + MW'(s2_aby2);
      s3_cd2 <= MW'(s2_cdx2) + MW'(s2_cdy2);
      s3_w2  <= MW'(s2_acx2) + MW'(s2_acy2);
      s3_den <= s2_d1 - s2_d2;
      s3_n1  <= s2_n1a - s2_n1b;
      s3_n2  <= s2_n2a - s2_n2b;
      s3_sa_lhs <= s2_sa_num[DW] ? (SLW'(-s2_sa_num) <<< F)
                 : (SLW'(s2_sa_num - $signed({1'b0, s2_sa_den})) <<< F);
      s3_sc_lhs <= s2_sc_num[DW] ? (SLW'(-s2_sc_num) <<< F)
                 : (SLW'(s2_sc_num - $signed({1'b0, s2_sc_den})) <<< F);
      s3_sa_rhs <= tol * s2_sa_den;
      s3_sc_rhs <= tol * s2_sc_den;
      s3_t2  <= s2_t2;
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_abx <= s2_abx;
      s3_aby <= s2_aby;
    end
  end

  // stage 4: degenerate tests, sign normalization
  logic [MW-1:0] n1_mag, n2_mag, tol_sh;
  assign n1_mag = s3_n1[PW-1] ? MW'(-s3_n1) : MW'(s3_n1);
  assign n2_mag = s3_n2[PW-1] ? MW'(-s3_n2) : MW'(s3_n2);
  assign tol_sh = MW'(tol) << F;

  deg_t                 s4_deg;
  logic [MW-1:0]        s4_dd, s4_an1, s4_ab2, s4_cd2;
  logic signed [PW-1:0] s4_m1, s4_m2;
  logic                 s4_negx, s4_negy;
  logic [CW-1:0]        s4_abx_mag, s4_aby_mag;
  logic [2*TW-1:0]      s4_t2;
  logic signed [CW-1:0] s4_ax, s4_ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_deg.ab_short <= s3_ab2 <= MW'(s3_t2);
      s4_deg.cd_short <= s3_cd2 <= MW'(s3_t2);
      s4_deg.w_short  <= s3_w2 <= MW'(s3_t2);
      s4_deg.a_ok     <= (n1_mag <= tol_sh)
                      && (SCW'(s3_sa_lhs) <= $signed(SCW'(s3_sa_rhs)));
      s4_deg.c_ok     <= (n2_mag <= tol_sh)
                      && (SCW'(s3_sc_lhs) <= $signed(SCW'(s3_sc_rhs)));
      s4_dd      <= s3_den[PW-1] ? MW'(-s3_den) : MW'(s3_den);
      s4_m1      <= s3_den[PW-1] ? -s3_n1 : s3_n1;
      s4_m2      <= s3_den[PW-1] ? -s3_n2 : s3_n2;
      s4_an1     <= n1_mag;
      s4_negx    <= s3_n1[PW-1] ^ s3_abx[DW-1] ^ s3_den[PW-1];
      s4_negy    <= s3_n1[PW-1] ^ s3_aby[DW-1] ^ s3_den[PW-1];
      s4_abx_mag <= s3_abx[DW-1] ? CW'(-s3_abx) : CW'(s3_abx);
      s4_aby_mag <= s3_aby[DW-1] ? CW'(-s3_aby) : CW'(s3_aby);
      s4_ab2     <= s3_ab2;
      s4_cd2     <= s3_cd2;
      s4_t2      <= s3_t2;
      s4_ax      <= s3_ax;
      s4_ay      <= s3_ay;
    end
  end

  // stage 5: partial products
  logic [HI_W-1:0] xh, ah, ch, nh;
  logic [LO_W-1:0] xl, al, cl, nl;
  assign xh = s4_dd[MW-1:LO_W];
  assign xl = s4_dd[LO_W-1:0];
  assign ah = s4_ab2[MW-1:LO_W];
  assign al = s4_ab2[LO_W-1:0];
  assign ch = s4_cd2[MW-1:LO_W];
  assign cl = s4_cd2[LO_W-1:0];
  assign nh = s4_an1[MW-1:LO_W];
  assign nl = s4_an1[LO_W-1:0];

  logic [2*HI_W-1:0]       s5_xx_hh, s5_p_hh;
  logic [HI_W+LO_W-1:0]    s5_xx_hl, s5_p_hl, s5_p_lh;
  logic [2*LO_W-1:0]       s5_xx_ll, s5_p_ll;
  logic [TW+HI_W-1:0]      s5_td_h;
  logic [TW+LO_W-1:0]      s5_td_l;
  logic [HI_W+CW-1:0]      s5_ax_h, s5_ay_h;
  logic [LO_W+CW-1:0]      s5_ax_l, s5_ay_l;
  logic signed [MLW-1:0]   s5_l1, s5_l2;
  logic [MW-1:0]           s5_dd;
  logic [2*TW-1:0]         s5_t2;
  deg_t                    s5_deg;
  logic                    s5_negx, s5_negy;
  logic signed [CW-1:0]    s5_ax, s5_ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_xx_hh <= xh * xh;
      s5_xx_hl <= xh * xl;
      s5_xx_ll <= xl * xl;
      s5_p_hh  <= ah * ch;
      s5_p_hl  <= ah * cl;
      s5_p_lh  <= al * ch;
      s5_p_ll  <= al * cl;
      s5_td_h  <= tol * xh;
      s5_td_l  <= tol * xl;
      s5_ax_h  <= nh * s4_abx_mag;
      s5_ax_l  <= nl * s4_abx_mag;
      s5_ay_h  <= nh * s4_aby_mag;
      s5_ay_l  <= nl * s4_aby_mag;
      s5_l1    <= s4_m1[PW-1] ? (MLW'(-s4_m1) <<< F)
                : (MLW'(s4_m1 - $signed({1'b0, s4_dd})) <<< F);
      s5_l2    <= s4_m2[PW-1] ? (MLW'(-s4_m2) <<< F)
                : (MLW'(s4_m2 - $signed({1'b0, s4_dd})) <<< F);
      s5_dd    <= s4_dd;
      s5_t2    <= s4_t2;
      s5_deg   <= s4_deg;
      s5_negx  <= s4_negx;
      s5_negy  <= s4_negy;
      s5_ax    <= s4_ax;
      s5_ay    <= s4_ay;
    end
  end

  // stage 6: product sums, divider operands
  logic [X2W-1:0]        s6_x2, s6_p;
  logic [MRW-1:0]        s6_tdd;
  logic [DIV_NW-1:0]     s6_nx, s6_ny;
  logic [DIV_DW-1:0]     s6_dv;
  logic signed [MLW-1:0] s6_l1, s6_l2;
  logic [2*TW-1:0]       s6_t2;
  deg_t                  s6_deg;
  logic                  s6_negx, s6_negy;
  logic signed [CW-1:0]  s6_ax, s6_ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_x2   <= (X2W'(s5_xx_hh) << (2 * LO_W)) + (X2W'(s5_xx_hl) << (LO_W + 1))
               + X2W'(s5_xx_ll);
      s6_p    <= (X2W'(s5_p_hh) << (2 * LO_W))
               + ((X2W'(s5_p_hl) + X2W'(s5_p_lh)) << LO_W) + X2W'(s5_p_ll);
      s6_tdd  <= (MRW'(s5_td_h) << LO_W) + MRW'(s5_td_l);
      s6_nx   <= (DIV_NW'(ANW'(s5_ax_h) << LO_W) << 1) + (DIV_NW'(s5_ax_l) << 1)
               + DIV_NW'(s5_dd);
      s6_ny   <= (DIV_NW'(ANW'(s5_ay_h) << LO_W) << 1) + (DIV_NW'(s5_ay_l) << 1)
               + DIV_NW'(s5_dd);
      s6_dv   <= {s5_dd, 1'b0};
      s6_l1   <= s5_l1;
      s6_l2   <= s5_l2;
      s6_t2   <= s5_t2;
      s6_deg  <= s5_deg;
      s6_negx <= s5_negx;
      s6_negy <= s5_negy;
      s6_ax   <= s5_ax;
      s6_ay   <= s5_ay;
    end
  end

  // crossing point
  logic signed [CW-1:0] res_x, res_y;

  spi_div u_div_x (
    .clk  (clk),
    .en   (adv),
    .num  (s6_nx),
    .den  (s6_dv),
    .neg  (s6_negx),
    .base (s6_ax),
    .res  (res_x)
  );

  spi_div u_div_y (
    .clk  (clk),
    .en   (adv),
    .num  (s6_ny),
    .den  (s6_dv),
    .neg  (s6_negy),
    .base (s6_ay),
    .res  (res_y)
  );

  // stage 7: tolerance products of the parallel test, range tests
  logic [4*LO_W-1:0]        p_pad;
  logic [LO_W+2*TW-1:0]     s7_r [4];
  logic [X2W-1:0]           s7_x2;
  logic [1:0]               s7_u;
  deg_t                     s7_deg;

  assign p_pad = (4 * LO_W)'(s6_p);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s7_r[k] <= p_pad[k*LO_W +: LO_W] * s6_t2;
      end
      s7_u[0] <= MCW'(s6_l1) <= $signed(MCW'(s6_tdd));
      s7_u[1] <= MCW'(s6_l2) <= $signed(MCW'(s6_tdd));
      s7_x2   <= s6_x2;
      s7_deg  <= s6_deg;
    end
  end

  // stage 8: parallel test right side
  logic [RW2-1:0] s8_r;
  logic [X2W-1:0] s8_x2;
  logic [1:0]     s8_u;
  deg_t           s8_deg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_r   <= (RW2'(s7_r[3]) << (3 * LO_W)) + (RW2'(s7_r[2]) << (2 * LO_W))
              + (RW2'(s7_r[1]) << LO_W) + RW2'(s7_r[0]);
      s8_x2  <= s7_x2;
      s8_u   <= s7_u;
      s8_deg <= s7_deg;
    end
  end

  // stage 9: case selection, then flags wait for the divider
  logic       par;
  spi_flags_t fl;
  spi_flags_t fdly [FD];

  always_comb begin
    par = (PCW'(s8_x2) << (2 * F)) <= PCW'(s8_r);
    fl  = '0;
    if (s8_deg.ab_short) begin
      fl.hit = s8_deg.cd_short ? s8_deg.w_short : s8_deg.a_ok;
    end else if (s8_deg.cd_short) begin
      fl.hit = s8_deg.c_ok;
    end else if (!par) begin
      fl.hit = s8_u[0] && s8_u[1];
      fl.pv  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fdly[0] <= fl;
      for (int k = 1; k < FD; k++) begin
        fdly[k] <= fdly[k-1];
      end
    end
  end

  assign m_axis_tdata = {(OUT_W - 1 - 2 * CW)'(0),
                         fdly[FD-1].pv ? res_y : COORD_MAX ^ COORD_MAX,
                         fdly[FD-1].pv ? res_x : COORD_MAX ^ COORD_MAX,
                         fdly[FD-1].hit};
  assign m_axis_tuser = fdly[FD-1].pv;

  a_rst_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during stall");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[1])
    else $error("accepted transfer lost at entry");

  a_no_bubble_in: assert property (@(posedge clk) disable iff (rst)
    adv && !s_axis_tvalid |=> !vld[1])
    else $error("transfer invented at entry");

endmodule

FILE: rtl/core/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div
// pipelined restoring divider, one quotient bit per stage, that places a
// rounded offset on a base coordinate and saturates to the coordinate range
// ----------------------------------------------------------------------------
module spi_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [spi_pkg::DIV_NW-1:0]     num,
  input  logic [spi_pkg::DIV_DW-1:0]     den,
  input  logic                           neg,
  input  logic signed [spi_pkg::CW-1:0]  base,
  output logic signed [spi_pkg::CW-1:0]  res
);
  import spi_pkg::*;

  typedef struct packed {
    logic [DIV_RW-1:0]      rem;
    logic [QB-1:0]          quo;
    logic [DIV_DW-1:0]      dv;
    logic                   neg;
    logic signed [CW-1:0]   base;
    logic                   ovf;
  } div_stage_t;

  div_stage_t st [QB+1];

  logic                   sat;
  logic signed [CW+5:0]   sum;

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem  <= DIV_RW'(num);
      st[0].quo  <= '0;
      st[0].dv   <= den;
      st[0].neg  <= neg;
      st[0].base <= base;
      st[0].ovf  <= DIV_RW'(num) >= (DIV_RW'(den) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DIV_RW-1:0] sh;
    logic              ge;
    div_stage_t        stage_next;
    assign sh = DIV_RW'(st[k-1].dv) << (QB - k);
    assign ge = st[k-1].rem >= sh;
    always_comb begin
      stage_next = st[k-1];
      if (ge) begin
        stage_next.rem         = st[k-1].rem - sh;
        stage_next.quo[QB - k] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= stage_next;
      end
    end
  end

  always_comb begin
    sat = st[QB].ovf || (st[QB].quo > Q_LIMIT);
    if (st[QB].neg) begin
      sum = (CW+6)'(st[QB].base) - $signed({2'b00, st[QB].quo});
    end else begin
      sum = (CW+6)'(st[QB].base) + $signed({2'b00, st[QB].quo});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sat) begin
        res <= st[QB].neg ? COORD_MIN : COORD_MAX;
      end else if (sum > (CW+6)'(COORD_MAX)) begin
        res <= COORD_MAX;
      end else if (sum < (CW+6)'(COORD_MIN)) begin
        res <= COORD_MIN;
      end else begin
        res <= CW'(sum);
      end
    end
  end

endmodule
